>>> rtl/fbf_pkg.sv
// ----------------------------------------------------------------------------
// fbf_pkg
// shared constants, codes and the command type of the band-pass fir filter
// ----------------------------------------------------------------------------
package fbf_pkg;

  // filter geometry
  localparam int MAX_ORDER = 32;
  localparam int MIN_ORDER = 2;
  localparam int TAPS      = MAX_ORDER + 1;
  localparam int IDX_W     = $clog2(TAPS);
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 40;
  localparam int RND_SHIFT = 15;
  localparam int ORDER_W   = 6;
  localparam int MODE_W    = 2;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(16);

  // rounding and saturation bounds in accumulator width
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // item kinds
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COEF    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic                       is_coef;  // coefficient write, else sample
    logic                       emit;     // sample produces a result
    logic [IDX_W-1:0]           idx;      // coefficient tap
    logic [IDX_W-1:0]           last;     // last tap index (effective order)
    logic signed [SAMPLE_W-1:0] data;     // sample or q1.15 coefficient
  } cmd_t;

endpackage

>>> rtl/fbf_front.sv
// ----------------------------------------------------------------------------
// fbf_front
// accepts items, keeps order register and fill count, classifies into commands
// ----------------------------------------------------------------------------
module fbf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [fbf_pkg::ORDER_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [fbf_pkg::MODE_W-1:0]          in_mode_i,
  input  logic [fbf_pkg::IDX_W-1:0]           in_idx_i,
  input  logic signed [fbf_pkg::SAMPLE_W-1:0] in_data_i,
  output logic                                in_ready_o,
  output logic                                cmd_valid_o,
  output fbf_pkg::cmd_t                       cmd_o,
  input  logic                                cmd_ready_i
);

  logic [fbf_pkg::ORDER_W-1:0] order_q;
  logic [fbf_pkg::IDX_W-1:0]   fill_q, fill_d;
  logic [fbf_pkg::IDX_W-1:0]   eff_order;
  logic                        accept;
  logic                        is_sample;
  logic                        is_coef;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (in_mode_i == fbf_pkg::MODE_SAMPLE);
  assign is_coef    = (in_mode_i == fbf_pkg::MODE_COEF);

  // clamp order into the supported range
  always_comb begin
    if (order_q < fbf_pkg::ORDER_W'(fbf_pkg::MIN_ORDER)) begin
      eff_order = fbf_pkg::IDX_W'(fbf_pkg::MIN_ORDER);
    end else if (order_q > fbf_pkg::ORDER_W'(fbf_pkg::MAX_ORDER)) begin
      eff_order = fbf_pkg::IDX_W'(fbf_pkg::MAX_ORDER);
    end else begin
      eff_order = fbf_pkg::IDX_W'(order_q);
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      case (in_mode_i)
        fbf_pkg::MODE_SAMPLE: begin
          if (fill_q < fbf_pkg::IDX_W'(fbf_pkg::TAPS)) begin
            fill_d = fill_q + 1'b1;
          end
        end
        fbf_pkg::MODE_RESTART: fill_d = '0;
        default: fill_d = fill_q;
      endcase
    end
  end

  assign cmd_valid_o = accept &&
                       (is_sample ||
                        (is_coef && (in_idx_i <= fbf_pkg::IDX_W'(fbf_pkg::MAX_ORDER))));

  always_comb begin
    cmd_o.is_coef = is_coef;
    cmd_o.emit    = is_sample && (fill_d >= eff_order + 1'b1);
    cmd_o.idx     = in_idx_i;
    cmd_o.last    = eff_order;
    cmd_o.data    = in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= fbf_pkg::ORDER_RESET;
      fill_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= cfg_data_i;
      end
      fill_q <= fill_d;
    end
  end

endmodule

>>> rtl/fbf_queue.sv
// ----------------------------------------------------------------------------
// fbf_queue
// short command queue decoupling the front from the back
// ----------------------------------------------------------------------------
module fbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbf_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fbf_pkg::cmd_t head_o
);

  fbf_pkg::cmd_t               slot_q [fbf_pkg::QDEPTH];
  logic [fbf_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [fbf_pkg::QCNT_W-1:0]  cnt_q;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == fbf_pkg::QCNT_W'(fbf_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == fbf_pkg::QPTR_W'(fbf_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == fbf_pkg::QPTR_W'(fbf_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/fbf_back.sv
// ----------------------------------------------------------------------------
// fbf_back
// history and coefficient memories, one multiply-accumulate a cycle, rounding
// ----------------------------------------------------------------------------
module fbf_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  fbf_pkg::cmd_t                        cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  output logic signed [fbf_pkg::SAMPLE_W-1:0]  out_value_o,
  output logic                                 out_sat_o,
  input  logic                                 out_ready_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;
  localparam int         IW       = fbf_pkg::IDX_W;
  localparam logic [IW-1:0] TOP_IDX = IW'(fbf_pkg::MAX_ORDER);

  logic [1:0] state_q, state_d;

  // circular sample history and coefficient store, valid bits give reset zeros
  logic signed [fbf_pkg::SAMPLE_W-1:0] hist_mem [fbf_pkg::TAPS];
  logic signed [fbf_pkg::COEF_W-1:0]   coef_mem [fbf_pkg::TAPS];
  logic [fbf_pkg::TAPS-1:0]            hval_q, cval_q;

  logic [IW-1:0] wp_q, rp_q, tap_q, last_q;
  logic          rd_vld_q, rd_last_q, mul_vld_q, mul_last_q;
  logic signed [fbf_pkg::SAMPLE_W-1:0] hrd_q;
  logic signed [fbf_pkg::COEF_W-1:0]   crd_q;
  logic signed [fbf_pkg::PROD_W-1:0]   prod_q;
  logic signed [fbf_pkg::ACC_W-1:0]    acc_q;
  logic signed [fbf_pkg::ACC_W-1:0]    rnd_sum, quot;

  logic out_vld_q, out_sat_q;
  logic signed [fbf_pkg::SAMPLE_W-1:0] out_val_q;
  logic out_free, out_load, start, sat_hi, sat_lo;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign start     = cmd_pop_o && !cmd_i.is_coef && cmd_i.emit;
  assign out_free  = !out_vld_q || out_ready_i;
  assign out_load  = (state_q == ST_DONE) && out_free;

  // round half up, then saturate
  assign rnd_sum = acc_q + fbf_pkg::RND_BIAS;
  assign quot    = rnd_sum >>> fbf_pkg::RND_SHIFT;
  assign sat_hi  = quot > fbf_pkg::SAT_HI;
  assign sat_lo  = quot < fbf_pkg::SAT_LO;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_RUN;
      ST_RUN:   if (tap_q == last_q) state_d = ST_DRAIN;
      ST_DRAIN: if (mul_vld_q && mul_last_q) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.is_coef) begin
      coef_mem[cmd_i.idx] <= cmd_i.data;
    end
    if (cmd_pop_o && !cmd_i.is_coef) begin
      hist_mem[wp_q] <= cmd_i.data;
    end
    hrd_q <= hval_q[rp_q] ? hist_mem[rp_q] : '0;
    crd_q <= cval_q[tap_q] ? coef_mem[tap_q] : '0;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= hrd_q * crd_q;
    if (start) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + fbf_pkg::ACC_W'(prod_q);
    end
    if (out_load) begin
      out_sat_q <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_val_q <= fbf_pkg::SAT_HI[fbf_pkg::SAMPLE_W-1:0];
      end else if (sat_lo) begin
        out_val_q <= fbf_pkg::SAT_LO[fbf_pkg::SAMPLE_W-1:0];
      end else begin
        out_val_q <= quot[fbf_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hval_q     <= '0;
      cval_q     <= '0;
      wp_q       <= '0;
      rp_q       <= '0;
      tap_q      <= '0;
      last_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      mul_vld_q  <= 1'b0;
      mul_last_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= (state_q == ST_RUN);
      rd_last_q  <= (state_q == ST_RUN) && (tap_q == last_q);
      mul_vld_q  <= rd_vld_q;
      mul_last_q <= rd_last_q;
      if (cmd_pop_o && cmd_i.is_coef) begin
        cval_q[cmd_i.idx] <= 1'b1;
      end
      if (cmd_pop_o && !cmd_i.is_coef) begin
        hval_q[wp_q] <= 1'b1;
        wp_q         <= (wp_q == TOP_IDX) ? '0 : wp_q + 1'b1;
      end
      if (start) begin
        rp_q   <= wp_q;
        tap_q  <= '0;
        last_q <= cmd_i.last;
      end else if (state_q == ST_RUN) begin
        rp_q  <= (rp_q == '0) ? TOP_IDX : rp_q - 1'b1;
        tap_q <= tap_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_val_q;
  assign out_sat_o   = out_sat_q;

`ifndef SYNTH
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (tap_q <= last_q))
    else $error("tap index ran past the last tap");

  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ((last_q <= TOP_IDX) && (last_q >= IW'(fbf_pkg::MIN_ORDER))))
    else $error("effective order out of range");

  a_mul_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld_q |-> $past(rd_vld_q))
    else $error("product without a preceding read");

  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_vld_q && mul_last_q) |-> (state_q == ST_DRAIN))
    else $error("final product outside drain");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_vld_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result lost while output stalled");
`endif

endmodule

>>> rtl/fir_bandpass_filter.sv
// ----------------------------------------------------------------------------
// fir_bandpass_filter
// direct-form fir filter, order 2..32, q1.15 coefficients, rounded saturated out
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer carries
//  s_axis    in         tuser: mode; tdata: coef_index, data_value
//  m_axis    out        tdata: filtered_value; tuser: saturated
//  cfg       in         filter_order (always ready)
//
//  a sample that yields a result occupies the back end while it takes the
//  command, runs the single shared multiply-accumulate over all m+1 taps,
//  drains the registered memory read and product, and rounds into the output
//  register; other items only write a memory in the back end; a two-entry
//  command queue lets the front keep taking items while the back end works
//  reset clears valid bits of both memories at once, so no clearing pass
//  a stalled output holds the back end in its final state until the transfer
//
module fir_bandpass_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fbf_pkg::ORDER_W-1:0]         cfg_data_i,   // filter_order
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata, // [5:0] coef_index, [21:6] data_value
  input  logic [fbf_pkg::MODE_W-1:0]          s_axis_tuser, // [1:0] mode
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata, // [15:0] filtered_value
  output logic [0:0]                          m_axis_tuser  // [0] saturated
);

  fbf_pkg::cmd_t front_cmd, head_cmd;
  logic          front_cmd_valid, q_full, q_valid, q_pop;
  logic          out_sat;
  logic signed [fbf_pkg::SAMPLE_W-1:0] out_value;

  // register writes are taken at any time
  assign cfg_ready_o = 1'b1;

  // front: classify items, track fill count and order
  fbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_idx_i    (s_axis_tdata[fbf_pkg::IDX_W-1:0]),
    .in_data_i   (s_axis_tdata[fbf_pkg::IDX_W +: fbf_pkg::SAMPLE_W]),
    .in_ready_o  (s_axis_tready),
    .cmd_valid_o (front_cmd_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (!q_full)
  );

  // decoupling queue
  fbf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_cmd_valid),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // back: memories, multiply-accumulate and output register
  fbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_sat_o   (out_sat),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_value;
  assign m_axis_tuser = out_sat;

endmodule
